/* design/rhc_pkg.sv */
package rhc_pkg;

    // CORDIC datapath widths: x and y in Q30 with headroom for the gain,
    // angle in 2^-32 turn units with sign and headroom.
    localparam int XY_W         = 33;
    localparam int Z_W          = 34;
    localparam int CORDIC_STEPS = 30;

    localparam logic signed [Z_W-1:0] TURN_QUARTER = 34'sd1073741824;
    localparam logic signed [Z_W-1:0] TURN_HALF    = 34'sd2147483648;

    // Reciprocal of three for the intensity, exact for sums up to 765.
    localparam logic [9:0] RECIP3     = 10'd683;
    localparam int         RECIP3_SHR = 11;

    // atan(2^-i) in units of 2^-32 turn.
    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335086,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41721,     32'd20860,
        32'd10430,     32'd5215,      32'd2607,      32'd1303,
        32'd651,       32'd325,       32'd162,       32'd81,
        32'd40,        32'd20,        32'd10,        32'd5,
        32'd2,         32'd1
    };

endpackage

/* design/rhc_channel_if.sv */
interface rhc_rgb_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source(output valid, output red, output green, output blue, input ready);
    modport sink(input valid, input red, input green, input blue, output ready);
endinterface

interface rhc_hsi_if;
    logic       valid;
    logic       ready;
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] intensity;

    modport source(output valid, output hue, output saturation, output intensity,
                   input ready);
    modport sink(input valid, input hue, input saturation, input intensity,
                 output ready);
endinterface

/* design/rhc_div_cell.sv */
module rhc_div_cell #(
    parameter int RW     = 34,
    parameter int DW     = 26,
    parameter int QW     = 8,
    parameter int SHIFT  = 0,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [RW-1:0]     i_rem,
    input  logic [DW-1:0]     i_div,
    input  logic [QW-1:0]     i_quot,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [RW-1:0]     o_rem,
    output logic [DW-1:0]     o_div,
    output logic [QW-1:0]     o_quot,
    output logic [SIDE_W-1:0] o_side
);

    localparam int CW = (RW > DW + QW) ? RW : DW + QW;

    logic              r_valid;
    logic [RW-1:0]     r_rem;
    logic [DW-1:0]     r_div;
    logic [QW-1:0]     r_quot;
    logic [SIDE_W-1:0] r_side;
    logic [CW-1:0]     w_trial;
    logic [CW-1:0]     w_rem_ext;
    logic              w_take;
    logic [RW-1:0]     n_rem;
    logic [QW-1:0]     n_quot;

    // One restoring step: this cell decides quotient bit SHIFT.
    assign w_trial   = CW'(i_div) << SHIFT;
    assign w_rem_ext = CW'(i_rem);
    assign w_take    = (w_rem_ext >= w_trial);
    assign n_rem     = w_take ? RW'(w_rem_ext - w_trial) : i_rem;
    assign n_quot    = w_take ? (i_quot | (QW'(1) << SHIFT)) : i_quot;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rem  <= n_rem;
            r_div  <= i_div;
            r_quot <= n_quot;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_div   = r_div;
    assign o_quot  = r_quot;
    assign o_side  = r_side;

endmodule

/* design/rhc_sqrt_cell.sv */
module rhc_sqrt_cell #(
    parameter int VW     = 48,
    parameter int QW     = 24,
    parameter int SHIFT  = 0,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [VW-1:0]     i_rem,
    input  logic [QW-1:0]     i_root,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [VW-1:0]     o_rem,
    output logic [QW-1:0]     o_root,
    output logic [SIDE_W-1:0] o_side
);

    localparam int TW = 2 * QW + 1;

    logic              r_valid;
    logic [VW-1:0]     r_rem;
    logic [QW-1:0]     r_root;
    logic [SIDE_W-1:0] r_side;
    logic [TW-1:0]     w_trial;
    logic [TW-1:0]     w_rem_ext;
    logic              w_take;

    // Setting root bit SHIFT raises the square by 2*root*2^SHIFT + 2^(2*SHIFT).
    assign w_trial   = (TW'(i_root) << (SHIFT + 1)) + (TW'(1) << (2 * SHIFT));
    assign w_rem_ext = TW'(i_rem);
    assign w_take    = (w_rem_ext >= w_trial);

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rem  <= w_take ? VW'(w_rem_ext - w_trial) : i_rem;
            r_root <= w_take ? (i_root | (QW'(1) << SHIFT)) : i_root;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_side  = r_side;

endmodule

/* design/rhc_cordic_cell.sv */
module rhc_cordic_cell #(
    parameter int STEP   = 0,
    parameter int SIDE_W = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [rhc_pkg::XY_W-1:0] i_x,
    input  logic signed [rhc_pkg::XY_W-1:0] i_y,
    input  logic signed [rhc_pkg::Z_W-1:0]  i_z,
    input  logic [SIDE_W-1:0]               i_side,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [rhc_pkg::XY_W-1:0] o_x,
    output logic signed [rhc_pkg::XY_W-1:0] o_y,
    output logic signed [rhc_pkg::Z_W-1:0]  o_z,
    output logic [SIDE_W-1:0]               o_side
);

    logic                            r_valid;
    logic signed [rhc_pkg::XY_W-1:0] r_x;
    logic signed [rhc_pkg::XY_W-1:0] r_y;
    logic signed [rhc_pkg::Z_W-1:0]  r_z;
    logic [SIDE_W-1:0]               r_side;
    logic signed [rhc_pkg::XY_W-1:0] w_xs;
    logic signed [rhc_pkg::XY_W-1:0] w_ys;
    logic signed [rhc_pkg::Z_W-1:0]  w_atan;
    logic                            w_pos;

    // Arithmetic shifts round towards minus infinity, as the angle table expects.
    assign w_xs   = i_x >>> STEP;
    assign w_ys   = i_y >>> STEP;
    assign w_atan = {{(rhc_pkg::Z_W - 32){1'b0}}, rhc_pkg::ATAN_TURNS[STEP]};
    assign w_pos  = !i_y[rhc_pkg::XY_W-1] && (i_y != '0);

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            if (w_pos) begin
                r_x <= i_x + w_ys;
                r_y <= i_y - w_xs;
                r_z <= i_z + w_atan;
            end else begin
                r_x <= i_x - w_ys;
                r_y <= i_y + w_xs;
                r_z <= i_z - w_atan;
            end
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

/* design/rgb_to_hsi_converter.sv */
// Channel  Direction  Modport  Payload
// i_pix    in         sink     red, green, blue (8 bit each)
// o_hsi    out        source   hue, saturation, intensity (8 bit each)
//
// One pixel is taken per clock unless o_hsi stalls; each cell of the chain holds
// one pixel. The chain is one input stage, 8 saturation division cells,
// FRAC_BITS+8 square-root cells, three set-up stages, 2*(FRAC_BITS+1)
// division and square-root cells, 30 CORDIC cells and the output register.
// Reset clears every valid bit; the payload registers are not reset.
// A stall on o_hsi backs up only as far as the first empty cell.
module rgb_to_hsi_converter #(
    parameter int FRAC_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    rhc_rgb_if.sink   i_pix,
    rhc_hsi_if.source o_hsi
);

    localparam int F = FRAC_BITS;
    localparam longint EPS_L = ((longint'(255) << F) + 5000) / 10000;
    localparam logic [F-1:0] EPS_V = F'(EPS_L);

    localparam int SAT_Q  = 8;
    localparam int SAT_RW = 18 + F;
    localparam int SAT_DW = 10 + F;
    localparam int SIDE_A = 35;

    localparam int NS     = 8 + F;
    localparam int S_VW   = 16 + 2 * F;
    localparam int SIDE_B = 27;

    localparam int NX     = F + 1;
    localparam int X_RW   = 9 + 2 * F;
    localparam int X_DW   = 9 + F;
    localparam int SIDE_C = 18;

    localparam int NY     = F + 1;
    localparam int Y_VW   = 2 * F + 1;
    localparam int SIDE_D = F + 19;

    localparam int NC     = rhc_pkg::CORDIC_STEPS;
    localparam int SIDE_E = 17;

    localparam logic [F:0] ONE_Q = {1'b1, {F{1'b0}}};

    // ---------------- input stage ----------------
    logic              r_s0_valid;
    logic [SAT_RW-1:0] r_s0_satnum;
    logic [SAT_DW-1:0] r_s0_sden;
    logic [SIDE_A-1:0] r_s0_side;

    logic [9:0]         w_sum;
    logic [7:0]         w_min;
    logic [19:0]        w_int_prod;
    logic signed [8:0]  w_rg;
    logic signed [8:0]  w_rb;
    logic signed [8:0]  w_gb;
    logic signed [18:0] w_d;
    logic signed [10:0] w_n2;
    logic [8:0]         w_absn2;
    logic [SAT_DW-1:0]  w_snum;
    logic [SAT_DW-1:0]  n_sden;
    logic [SAT_RW-1:0]  n_satnum;

    assign w_sum = 10'(i_pix.red) + 10'(i_pix.green) + 10'(i_pix.blue);
    always_comb begin
        w_min = i_pix.red;
        if (i_pix.green < w_min) begin
            w_min = i_pix.green;
        end
        if (i_pix.blue < w_min) begin
            w_min = i_pix.blue;
        end
    end
    assign w_int_prod = w_sum * rhc_pkg::RECIP3;
    assign w_rg  = signed'({1'b0, i_pix.red}) - signed'({1'b0, i_pix.green});
    assign w_rb  = signed'({1'b0, i_pix.red}) - signed'({1'b0, i_pix.blue});
    assign w_gb  = signed'({1'b0, i_pix.green}) - signed'({1'b0, i_pix.blue});
    assign w_d   = 19'(w_rg * w_rg) + 19'(w_rb * w_gb);
    assign w_n2  = signed'({2'b00, i_pix.red, 1'b0}) - signed'({3'b000, i_pix.green})
                 - signed'({3'b000, i_pix.blue});
    assign w_absn2 = w_n2[10] ? 9'(-w_n2) : w_n2[8:0];
    assign w_snum  = {(w_sum - 10'(3 * w_min)), {F{1'b0}}} + SAT_DW'(EPS_V);
    assign n_sden  = {w_sum, {F{1'b0}}} + SAT_DW'(EPS_V);
    // Multiplying by 255 is a shift and a subtract.
    assign n_satnum = {w_snum, 8'b0} - SAT_RW'(w_snum);

    logic w_a_valid [0:SAT_Q];
    logic w_a_ready [0:SAT_Q];
    logic [SAT_RW-1:0] w_a_rem  [0:SAT_Q];
    logic [SAT_DW-1:0] w_a_div  [0:SAT_Q];
    logic [SAT_Q-1:0]  w_a_quot [0:SAT_Q];
    logic [SIDE_A-1:0] w_a_side [0:SAT_Q];

    assign i_pix.ready = !r_s0_valid || w_a_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_s0_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pix.ready && i_pix.valid) begin
            r_s0_satnum <= n_satnum;
            r_s0_sden   <= n_sden;
            r_s0_side   <= {w_d[15:0], w_absn2, w_n2[10], (i_pix.blue > i_pix.green),
                            w_int_prod[rhc_pkg::RECIP3_SHR +: 8]};
        end
    end

    // ---------------- saturation division ----------------
    assign w_a_valid[0] = r_s0_valid;
    assign w_a_rem[0]   = r_s0_satnum;
    assign w_a_div[0]   = r_s0_sden;
    assign w_a_quot[0]  = '0;
    assign w_a_side[0]  = r_s0_side;

    genvar gj;
    for (gj = 0; gj < SAT_Q; gj++) begin : g_sat
        rhc_div_cell #(
            .RW(SAT_RW), .DW(SAT_DW), .QW(SAT_Q), .SHIFT(SAT_Q - 1 - gj), .SIDE_W(SIDE_A)
        ) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_valid(w_a_valid[gj]), .o_ready(w_a_ready[gj]),
            .i_rem(w_a_rem[gj]), .i_div(w_a_div[gj]), .i_quot(w_a_quot[gj]),
            .i_side(w_a_side[gj]),
            .o_valid(w_a_valid[gj+1]), .i_ready(w_a_ready[gj+1]),
            .o_rem(w_a_rem[gj+1]), .o_div(w_a_div[gj+1]), .o_quot(w_a_quot[gj+1]),
            .o_side(w_a_side[gj+1])
        );
    end

    // ---------------- square root of the angle denominator ----------------
    logic w_b_valid [0:NS];
    logic w_b_ready [0:NS];
    logic [S_VW-1:0]   w_b_rem  [0:NS];
    logic [NS-1:0]     w_b_root [0:NS];
    logic [SIDE_B-1:0] w_b_side [0:NS];

    assign w_b_valid[0]    = w_a_valid[SAT_Q];
    assign w_a_ready[SAT_Q] = w_b_ready[0];
    assign w_b_rem[0]      = {w_a_side[SAT_Q][34:19], {(2 * F){1'b0}}};
    assign w_b_root[0]     = '0;
    assign w_b_side[0]     = {w_a_side[SAT_Q][18:0], w_a_quot[SAT_Q]};

    for (gj = 0; gj < NS; gj++) begin : g_sqs
        rhc_sqrt_cell #(
            .VW(S_VW), .QW(NS), .SHIFT(NS - 1 - gj), .SIDE_W(SIDE_B)
        ) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_valid(w_b_valid[gj]), .o_ready(w_b_ready[gj]),
            .i_rem(w_b_rem[gj]), .i_root(w_b_root[gj]), .i_side(w_b_side[gj]),
            .o_valid(w_b_valid[gj+1]), .i_ready(w_b_ready[gj+1]),
            .o_rem(w_b_rem[gj+1]), .o_root(w_b_root[gj+1]), .o_side(w_b_side[gj+1])
        );
    end

    // ---------------- divider set-up ----------------
    logic              r_c_valid;
    logic [X_RW-1:0]   r_c_rem;
    logic [X_DW-1:0]   r_c_div;
    logic [SIDE_C-1:0] r_c_side;
    logic [NS-1:0]     w_den;

    logic w_c_valid [0:NX];
    logic w_c_ready [0:NX];
    logic [X_RW-1:0]   w_c_rem  [0:NX];
    logic [X_DW-1:0]   w_c_div  [0:NX];
    logic [NX-1:0]     w_c_quot [0:NX];
    logic [SIDE_C-1:0] w_c_side [0:NX];

    assign w_den          = w_b_root[NS] + NS'(EPS_V);
    assign w_b_ready[NS]  = !r_c_valid || w_c_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_b_ready[NS]) begin
            r_c_valid <= w_b_valid[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_ready[NS] && w_b_valid[NS]) begin
            r_c_rem  <= {w_b_side[NS][26:18], {(2 * F){1'b0}}};
            r_c_div  <= {w_den, 1'b0};
            r_c_side <= w_b_side[NS][17:0];
        end
    end

    assign w_c_valid[0] = r_c_valid;
    assign w_c_rem[0]   = r_c_rem;
    assign w_c_div[0]   = r_c_div;
    assign w_c_quot[0]  = '0;
    assign w_c_side[0]  = r_c_side;

    for (gj = 0; gj < NX; gj++) begin : g_divx
        rhc_div_cell #(
            .RW(X_RW), .DW(X_DW), .QW(NX), .SHIFT(NX - 1 - gj), .SIDE_W(SIDE_C)
        ) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_valid(w_c_valid[gj]), .o_ready(w_c_ready[gj]),
            .i_rem(w_c_rem[gj]), .i_div(w_c_div[gj]), .i_quot(w_c_quot[gj]),
            .i_side(w_c_side[gj]),
            .o_valid(w_c_valid[gj+1]), .i_ready(w_c_ready[gj+1]),
            .o_rem(w_c_rem[gj+1]), .o_div(w_c_div[gj+1]), .o_quot(w_c_quot[gj+1]),
            .o_side(w_c_side[gj+1])
        );
    end

    // ---------------- sine term: 1 - x^2 ----------------
    logic              r_d_valid;
    logic [Y_VW-1:0]   r_d_rem;
    logic [SIDE_D-1:0] r_d_side;
    logic [F:0]        w_xm;
    logic [2*F+1:0]    w_xsq;

    logic w_d_valid [0:NY];
    logic w_d_ready [0:NY];
    logic [Y_VW-1:0]   w_d_rem  [0:NY];
    logic [NY-1:0]     w_d_root [0:NY];
    logic [SIDE_D-1:0] w_d_side [0:NY];

    assign w_xm  = (w_c_quot[NX] > ONE_Q) ? ONE_Q : w_c_quot[NX];
    assign w_xsq = w_xm * w_xm;
    assign w_c_ready[NX] = !r_d_valid || w_d_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (w_c_ready[NX]) begin
            r_d_valid <= w_c_valid[NX];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_c_ready[NX] && w_c_valid[NX]) begin
            r_d_rem  <= {1'b1, {(2 * F){1'b0}}} - w_xsq[2*F:0];
            r_d_side <= {w_xm, w_c_side[NX]};
        end
    end

    assign w_d_valid[0] = r_d_valid;
    assign w_d_rem[0]   = r_d_rem;
    assign w_d_root[0]  = '0;
    assign w_d_side[0]  = r_d_side;

    for (gj = 0; gj < NY; gj++) begin : g_sqy
        rhc_sqrt_cell #(
            .VW(Y_VW), .QW(NY), .SHIFT(NY - 1 - gj), .SIDE_W(SIDE_D)
        ) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_valid(w_d_valid[gj]), .o_ready(w_d_ready[gj]),
            .i_rem(w_d_rem[gj]), .i_root(w_d_root[gj]), .i_side(w_d_side[gj]),
            .o_valid(w_d_valid[gj+1]), .i_ready(w_d_ready[gj+1]),
            .o_rem(w_d_rem[gj+1]), .o_root(w_d_root[gj+1]), .o_side(w_d_side[gj+1])
        );
    end

    // ---------------- CORDIC set-up ----------------
    logic                            r_e_valid;
    logic signed [rhc_pkg::XY_W-1:0] r_e_x;
    logic signed [rhc_pkg::XY_W-1:0] r_e_y;
    logic signed [rhc_pkg::Z_W-1:0]  r_e_z;
    logic [SIDE_E-1:0]               r_e_side;
    logic [F:0]                      w_fxm;
    logic signed [rhc_pkg::XY_W-1:0] w_mag_x;
    logic signed [rhc_pkg::XY_W-1:0] w_mag_y;
    logic                            w_rot;

    logic w_e_valid [0:NC];
    logic w_e_ready [0:NC];
    logic signed [rhc_pkg::XY_W-1:0] w_e_x [0:NC];
    logic signed [rhc_pkg::XY_W-1:0] w_e_y [0:NC];
    logic signed [rhc_pkg::Z_W-1:0]  w_e_z [0:NC];
    logic [SIDE_E-1:0]               w_e_side [0:NC];

    assign w_fxm   = w_d_side[NY][SIDE_D-1:18];
    assign w_mag_x = rhc_pkg::XY_W'(w_fxm) << (30 - F);
    assign w_mag_y = rhc_pkg::XY_W'(w_d_root[NY]) << (30 - F);
    // A negative cosine is turned a quarter turn first so that x starts positive.
    assign w_rot   = w_d_side[NY][17] && (w_fxm != '0);
    assign w_d_ready[NY] = !r_e_valid || w_e_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (w_d_ready[NY]) begin
            r_e_valid <= w_d_valid[NY];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_d_ready[NY] && w_d_valid[NY]) begin
            r_e_x    <= w_rot ? w_mag_y : w_mag_x;
            r_e_y    <= w_rot ? w_mag_x : w_mag_y;
            r_e_z    <= w_rot ? rhc_pkg::TURN_QUARTER : '0;
            r_e_side <= w_d_side[NY][16:0];
        end
    end

    assign w_e_valid[0] = r_e_valid;
    assign w_e_x[0]     = r_e_x;
    assign w_e_y[0]     = r_e_y;
    assign w_e_z[0]     = r_e_z;
    assign w_e_side[0]  = r_e_side;

    for (gj = 0; gj < NC; gj++) begin : g_cordic
        rhc_cordic_cell #(
            .STEP(gj), .SIDE_W(SIDE_E)
        ) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_valid(w_e_valid[gj]), .o_ready(w_e_ready[gj]),
            .i_x(w_e_x[gj]), .i_y(w_e_y[gj]), .i_z(w_e_z[gj]), .i_side(w_e_side[gj]),
            .o_valid(w_e_valid[gj+1]), .i_ready(w_e_ready[gj+1]),
            .o_x(w_e_x[gj+1]), .o_y(w_e_y[gj+1]), .o_z(w_e_z[gj+1]),
            .o_side(w_e_side[gj+1])
        );
    end

    // ---------------- hue scaling and output register ----------------
    logic        r_out_valid;
    logic [7:0]  r_out_hue;
    logic [7:0]  r_out_sat;
    logic [7:0]  r_out_int;
    logic        r_out_bgt;
    logic [31:0] w_zc;
    logic [32:0] w_turn;
    logic [40:0] w_hprod;
    logic [8:0]  w_h9;

    always_comb begin
        if (w_e_z[NC][rhc_pkg::Z_W-1]) begin
            w_zc = '0;
        end else if (w_e_z[NC] > rhc_pkg::TURN_HALF) begin
            w_zc = 32'h8000_0000;
        end else begin
            w_zc = w_e_z[NC][31:0];
        end
    end
    assign w_turn  = w_e_side[NC][16] ? (33'h1_0000_0000 - {1'b0, w_zc}) : {1'b0, w_zc};
    assign w_hprod = {w_turn, 8'b0} - {8'b0, w_turn};
    assign w_h9    = w_hprod[40:32];

    assign w_e_ready[NC] = !r_out_valid || o_hsi.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_e_ready[NC]) begin
            r_out_valid <= w_e_valid[NC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_e_ready[NC] && w_e_valid[NC]) begin
            r_out_hue <= (w_h9 > 9'd255) ? 8'd255 : w_h9[7:0];
            r_out_int <= w_e_side[NC][15:8];
            r_out_sat <= w_e_side[NC][7:0];
            r_out_bgt <= w_e_side[NC][16];
        end
    end

    assign o_hsi.valid      = r_out_valid;
    assign o_hsi.hue        = r_out_hue;
    assign o_hsi.saturation = r_out_sat;
    assign o_hsi.intensity  = r_out_int;

    // ---------------- assertions ----------------
    a_reset_clears_out: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !r_out_valid)
        else $error("output valid set straight after reset");

    a_request_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix.valid && i_pix.ready |=> r_s0_valid)
        else $error("accepted request did not reach the input stage");

    a_dark_saturation: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_int == 8'd0) |-> (r_out_sat == 8'd255))
        else $error("near-black pixel without full saturation");

    a_upper_half_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_bgt |-> (r_out_hue <= 8'd127))
        else $error("hue beyond half a turn while blue does not exceed green");

endmodule

/* sim/rgb_to_hsi_converter_tb.sv */
`timescale 1ns / 1ps

module rgb_to_hsi_converter_tb;

    localparam int FRAC     = 16;
    localparam int LATENCY  = 3 * FRAC + 53;
    localparam int N_RANDOM = 1900;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] intensity;
    } hsi_t;

    // Bit-exact fixed-point model of the conversion.
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > v) bt = bt >> 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v = v - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    function automatic longint floor_shift(longint v, int s);
        if (v >= 0) return v >>> s;
        return -(((-v - 1) >>> s) + 1);
    endfunction

    function automatic longint vector_angle(longint x, longint y);
        longint z;
        longint t;
        longint xs;
        longint ys;
        z = 0;
        if (x < 0) begin
            t = x;
            x = y;
            y = -t;
            z = longint'(rhc_pkg::TURN_QUARTER);
        end
        for (int i = 0; i < rhc_pkg::CORDIC_STEPS; i++) begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(rhc_pkg::ATAN_TURNS[i]);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(rhc_pkg::ATAN_TURNS[i]);
            end
        end
        if (z < 0) z = 0;
        if (z > longint'(rhc_pkg::TURN_HALF)) z = longint'(rhc_pkg::TURN_HALF);
        return z;
    endfunction

    function automatic hsi_t convert_pixel(logic [7:0] red, logic [7:0] green,
                                           logic [7:0] blue);
        longint r, g, b, d, n2, cx, cy;
        longint unsigned one, eps, s, den, mag, xm, ym, turn, hue;
        longint unsigned sum, mn, snum, sden, sat;
        hsi_t res;
        r = red;
        g = green;
        b = blue;
        one = 64'd1 << FRAC;
        eps = ((64'd255 << FRAC) + 5000) / 10000;
        d = (r - g) * (r - g) + (r - b) * (g - b);
        n2 = 2 * r - g - b;
        if (d < 0) d = 0;
        s = int_sqrt(longint'(d) << (2 * FRAC));
        den = s + eps;
        if (den == 0) den = 1;
        mag = longint'(n2 < 0 ? -n2 : n2) << (2 * FRAC);
        xm = mag / (2 * den);
        if (xm > one) xm = one;
        ym = int_sqrt(one * one - xm * xm);
        cx = longint'(xm << (30 - FRAC));
        cy = longint'(ym << (30 - FRAC));
        if (n2 < 0) cx = -cx;
        turn = vector_angle(cx, cy);
        if (b > g) turn = (64'd1 << 32) - turn;
        hue = (turn * 255) >> 32;
        if (hue > 255) hue = 255;
        sum = r + g + b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        snum = ((sum - 3 * mn) << FRAC) + eps;
        sden = (sum << FRAC) + eps;
        sat = (255 * snum) / sden;
        if (sat > 255) sat = 255;
        res.hue = hue[7:0];
        res.saturation = sat[7:0];
        res.intensity = 8'(sum / 3);
        return res;
    endfunction

    class hsi_scoreboard;
        hsi_t pending[$];
        int   errors;
        int   checked;

        function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            pending.push_back(convert_pixel(r, g, b));
        endfunction

        function void check_result(hsi_t got);
            hsi_t want;
            if (pending.size() == 0) begin
                $error("unexpected result hue=%0d sat=%0d int=%0d",
                       got.hue, got.saturation, got.intensity);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.hue !== want.hue) begin
                $error("hue: expected %0d, got %0d", want.hue, got.hue);
                errors++;
            end
            if (got.saturation !== want.saturation) begin
                $error("saturation: expected %0d, got %0d", want.saturation,
                       got.saturation);
                errors++;
            end
            if (got.intensity !== want.intensity) begin
                $error("intensity: expected %0d, got %0d", want.intensity,
                       got.intensity);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    longint cycles;
    bit     no_idle;      // sender and receiver run flat out when set
    bit     hold_sink;    // long back-pressure stretch in progress
    hsi_scoreboard hsi_exp;

    rhc_rgb_if pix_bus ();
    rhc_hsi_if hsi_bus ();

    rgb_to_hsi_converter #(.FRAC_BITS(FRAC)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_bus.sink),
        .o_hsi   (hsi_bus.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        pix_bus.valid = 1'b0;
        pix_bus.red = '0;
        pix_bus.green = '0;
        pix_bus.blue = '0;
        hsi_bus.ready = 1'b0;
        i_rst_n = 1'b0;
        hsi_exp = new();
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end
    initial cycles = 0;

    // Receiver: random stalls, always ready under no_idle, long hold under hold_sink.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hsi_bus.ready <= 1'b0;
        end else begin
            if (hsi_bus.valid && hsi_bus.ready)
                hsi_exp.check_result({hsi_bus.hue, hsi_bus.saturation,
                                      hsi_bus.intensity});
            if (hold_sink) hsi_bus.ready <= 1'b0;
            else if (no_idle) hsi_bus.ready <= 1'b1;
            else hsi_bus.ready <= ($urandom_range(99) >= 27);
        end
    end

    // Offers one request and waits until it is taken; gaps come before it.
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        while (!no_idle && $urandom_range(99) < 27) begin
            pix_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_bus.valid <= 1'b1;
        pix_bus.red <= r;
        pix_bus.green <= g;
        pix_bus.blue <= b;
        @(posedge i_clk);
        while (!pix_bus.ready) @(posedge i_clk);
        hsi_exp.note_pixel(r, g, b);
    endtask

    task automatic drain_results();
        pix_bus.valid <= 1'b0;
        while (hsi_exp.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_random();
        int sel;
        logic [7:0] base;
        sel = $urandom_range(9);
        base = 8'($urandom);
        case (sel)
            0: send_pixel(base, base, base);
            1: send_pixel(base, base, 8'(base + $urandom_range(3)));
            2: send_pixel(base, 8'(base + $urandom_range(2)), base);
            default: send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        endcase
    endtask

    initial begin
        hold_sink = 1'b0;
        no_idle = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Extremes, grey and black, primaries, secondaries, and blue just above green.
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd1, 8'd1, 8'd1);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd1);
        send_pixel(8'd200, 8'd100, 8'd101);
        send_pixel(8'd255, 8'd254, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd1);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd170, 8'd85, 8'd85);
        send_pixel(8'd85, 8'd170, 8'd170);
        send_pixel(8'd254, 8'd1, 8'd127);

        // The sender pauses until the pipe is empty.
        drain_results();

        // Receiver holds off long enough for the pipeline to fill and stall.
        hold_sink = 1'b1;
        fork
            begin
                repeat (3 * LATENCY) @(posedge i_clk);
                hold_sink = 1'b0;
            end
            begin
                for (int k = 0; k < 2 * LATENCY; k++) send_random();
            end
        join

        for (int k = 0; k < N_RANDOM - 2 * LATENCY; k++) begin
            no_idle = (k >= 600 && k < 900);
            send_random();
        end
        no_idle = 1'b0;

        drain_results();
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Checked %0d HSI results from directed corner pixels and random,",
                 hsi_exp.checked);
        $display("near-grey pixels, with back-pressure, idling and a flat-out burst.");
        if (hsi_exp.errors == 0 && hsi_exp.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
